### rtl/yuyv_chroma_key_to_rgb_macros.svh
// Assertion macros shared by the YUYV chroma-key converter.
`ifndef YUYV_CHROMA_KEY_TO_RGB_MACROS_SVH
`define YUYV_CHROMA_KEY_TO_RGB_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define YCK_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("yck check failed");

// Next-cycle implication, disabled during reset.
`define YCK_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("yck check failed");

`endif

### rtl/yck_pkg.sv
// Types, constants and helper functions of the YUYV chroma-key converter.
`timescale 1ns / 1ps

package yck_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned PROD_W = 25;  // holds 116130 * -128 with sign
  localparam int unsigned TERM_W = 9;   // truncated chroma term, +/-226 max
  localparam int unsigned SUM_W  = 11;  // luma plus term, -226..480
  localparam int unsigned FRAC_BITS = 16;

  localparam logic signed [PROD_W-1:0] COEF_CR_R = PROD_W'(91881);
  localparam logic signed [PROD_W-1:0] COEF_CB_G = PROD_W'(22544);
  localparam logic signed [PROD_W-1:0] COEF_CR_G = PROD_W'(46793);
  localparam logic signed [PROD_W-1:0] COEF_CB_B = PROD_W'(116130);
  localparam logic signed [PROD_W-1:0] FRAC_ROUND = PROD_W'((1 << FRAC_BITS) - 1);

  localparam logic [PIX_W-1:0] CHANNEL_MAX = PIX_W'(255);
  localparam logic [PIX_W-1:0] THRESHOLD_RESET = PIX_W'(128);

  // Register indexes on the configuration port
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_CB_THRESHOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_CR_THRESHOLD = 1'b1;

  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] chroma_red;
    logic [PIX_W-1:0] bg_blue_first;
    logic [PIX_W-1:0] bg_green_first;
    logic [PIX_W-1:0] bg_red_first;
    logic [PIX_W-1:0] bg_blue_second;
    logic [PIX_W-1:0] bg_green_second;
    logic [PIX_W-1:0] bg_red_second;
  } in_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] out_blue_first;
    logic [PIX_W-1:0] out_green_first;
    logic [PIX_W-1:0] out_red_first;
    logic [PIX_W-1:0] out_blue_second;
    logic [PIX_W-1:0] out_green_second;
    logic [PIX_W-1:0] out_red_second;
    logic             is_background;
  } out_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] cb_threshold;
    logic [PIX_W-1:0] cr_threshold;
  } cfg_t;

  // Data that rides along the pipeline untouched until the last stage
  typedef struct packed {
    logic [PIX_W-1:0] luma_first;
    logic [PIX_W-1:0] luma_second;
    logic [PIX_W-1:0] bg_blue_first;
    logic [PIX_W-1:0] bg_green_first;
    logic [PIX_W-1:0] bg_red_first;
    logic [PIX_W-1:0] bg_blue_second;
    logic [PIX_W-1:0] bg_green_second;
    logic [PIX_W-1:0] bg_red_second;
    logic             keyed;
  } side_t;

  typedef struct packed {
    side_t                   side;
    logic signed [PIX_W-1:0] du;
    logic signed [PIX_W-1:0] dv;
  } key_t;

  typedef struct packed {
    side_t                    side;
    logic signed [PROD_W-1:0] prod_r;
    logic signed [PROD_W-1:0] prod_g_cb;
    logic signed [PROD_W-1:0] prod_g_cr;
    logic signed [PROD_W-1:0] prod_b;
  } prod_t;

  typedef struct packed {
    side_t                    side;
    logic signed [TERM_W-1:0] term_r;
    logic signed [TERM_W-1:0] term_g;
    logic signed [TERM_W-1:0] term_b;
  } term_t;

  // Drop the fraction bits, rounding toward zero
  function automatic logic signed [TERM_W-1:0] drop_frac(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] adj;
    adj = v + ((v < 0) ? FRAC_ROUND : PROD_W'(0));
    return TERM_W'(adj >>> FRAC_BITS);
  endfunction

  function automatic logic [PIX_W-1:0] clamp_channel(input logic signed [SUM_W-1:0] v);
    logic [PIX_W-1:0] res;
    if (v < 0) begin
      res = '0;
    end else if (v > $signed(SUM_W'(CHANNEL_MAX))) begin
      res = CHANNEL_MAX;
    end else begin
      res = v[PIX_W-1:0];
    end
    return res;
  endfunction

endpackage

### rtl/yck_in_if.sv
// Input channel: one YUYV macropixel plus two background pixels per request.
`timescale 1ns / 1ps

interface yck_in_if;
  logic              valid;
  logic              ready;
  yck_pkg::in_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/yck_out_if.sv
// Output channel: two BGR pixels and the background flag per request.
`timescale 1ns / 1ps

interface yck_out_if;
  logic               valid;
  logic               ready;
  yck_pkg::out_item_t data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

### rtl/yuyv_chroma_key_to_rgb.sv
// YUYV chroma-key to BGR converter: four-stage pipeline.
// Throughput: one macropixel per cycle while the output is not stalled;
// each stage holds one request and frees as it drains.
// Stages: key decision, coefficient products, term truncation, luma add, clamp and background select.
// Reset: clears all stage valid bits and sets both thresholds to 128.
`timescale 1ns / 1ps
`include "yuyv_chroma_key_to_rgb_macros.svh"

module yuyv_chroma_key_to_rgb (
  input  logic                               clk,
  input  logic                               rst,
  yck_in_if.sink                             in_ch,
  yck_out_if.source                          out_ch,
  input  logic                               cfg_we,
  input  logic [yck_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [yck_pkg::PIX_W-1:0]          cfg_data
);

  yck_pkg::cfg_t  cfg;
  yck_pkg::key_t  key_data;
  yck_pkg::prod_t prod_data;
  yck_pkg::term_t term_data;
  logic key_valid, key_ready;
  logic prod_valid, prod_ready;
  logic term_valid, term_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cb_threshold <= yck_pkg::THRESHOLD_RESET;
      cfg.cr_threshold <= yck_pkg::THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        yck_pkg::REG_CB_THRESHOLD: cfg.cb_threshold <= cfg_data;
        yck_pkg::REG_CR_THRESHOLD: cfg.cr_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  yck_key u_key (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .up_valid (in_ch.valid),
    .up_ready (in_ch.ready),
    .up_data  (in_ch.data),
    .dn_valid (key_valid),
    .dn_ready (key_ready),
    .dn_data  (key_data)
  );

  yck_product u_product (
    .clk      (clk),
    .rst      (rst),
    .up_valid (key_valid),
    .up_ready (key_ready),
    .up_data  (key_data),
    .dn_valid (prod_valid),
    .dn_ready (prod_ready),
    .dn_data  (prod_data)
  );

  yck_term u_term (
    .clk      (clk),
    .rst      (rst),
    .up_valid (prod_valid),
    .up_ready (prod_ready),
    .up_data  (prod_data),
    .dn_valid (term_valid),
    .dn_ready (term_ready),
    .dn_data  (term_data)
  );

  yck_mix u_mix (
    .clk      (clk),
    .rst      (rst),
    .up_valid (term_valid),
    .up_ready (term_ready),
    .up_data  (term_data),
    .dn_valid (out_ch.valid),
    .dn_ready (out_ch.ready),
    .dn_data  (out_ch.data)
  );

  // an empty output register opens the whole pipe
  `YCK_ASSERT_NOW(a_empty_out_accepts, clk, rst, !out_ch.valid, in_ch.ready)
  // a stalled stage keeps its request
  `YCK_ASSERT_NEXT(a_term_holds, clk, rst, term_valid && !term_ready, term_valid)
  `YCK_ASSERT_NEXT(a_key_holds, clk, rst, key_valid && !key_ready, key_valid && $stable(key_data))
  // nothing comes out right after reset
  `YCK_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !out_ch.valid && !term_valid)

endmodule

### rtl/yck_key.sv
// Stage 1: key decision and chroma offset removal.
`timescale 1ns / 1ps

module yck_key (
  input  logic              clk,
  input  logic              rst,
  input  yck_pkg::cfg_t     cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  yck_pkg::in_item_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output yck_pkg::key_t     dn_data
);

  yck_pkg::key_t stage_next;

  assign up_ready = !dn_valid || dn_ready;

  always_comb begin
    stage_next.side.luma_first      = up_data.luma_first;
    stage_next.side.luma_second     = up_data.luma_second;
    stage_next.side.bg_blue_first   = up_data.bg_blue_first;
    stage_next.side.bg_green_first  = up_data.bg_green_first;
    stage_next.side.bg_red_first    = up_data.bg_red_first;
    stage_next.side.bg_blue_second  = up_data.bg_blue_second;
    stage_next.side.bg_green_second = up_data.bg_green_second;
    stage_next.side.bg_red_second   = up_data.bg_red_second;
    stage_next.side.keyed = (up_data.chroma_blue > cfg.cb_threshold) &&
                            (up_data.chroma_red < cfg.cr_threshold);
    // x - 128 on a byte is a flip of the top bit read as signed
    stage_next.du = {~up_data.chroma_blue[7], up_data.chroma_blue[6:0]};
    stage_next.dv = {~up_data.chroma_red[7], up_data.chroma_red[6:0]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

### rtl/yck_product.sv
// Stage 2: chroma coefficient products.
`timescale 1ns / 1ps

module yck_product (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  yck_pkg::key_t   up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output yck_pkg::prod_t  dn_data
);

  yck_pkg::prod_t stage_next;
  logic signed [yck_pkg::PROD_W-1:0] du_ext;
  logic signed [yck_pkg::PROD_W-1:0] dv_ext;

  assign up_ready = !dn_valid || dn_ready;
  assign du_ext = yck_pkg::PROD_W'(up_data.du);
  assign dv_ext = yck_pkg::PROD_W'(up_data.dv);

  always_comb begin
    stage_next.side      = up_data.side;
    stage_next.prod_r    = dv_ext * yck_pkg::COEF_CR_R;
    stage_next.prod_g_cb = du_ext * yck_pkg::COEF_CB_G;
    stage_next.prod_g_cr = dv_ext * yck_pkg::COEF_CR_G;
    stage_next.prod_b    = du_ext * yck_pkg::COEF_CB_B;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

### rtl/yck_term.sv
// Stage 3: green sum and truncation of the chroma terms.
`timescale 1ns / 1ps

module yck_term (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  yck_pkg::prod_t  up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output yck_pkg::term_t  dn_data
);

  yck_pkg::term_t stage_next;
  logic signed [yck_pkg::PROD_W-1:0] green_sum;

  assign up_ready = !dn_valid || dn_ready;
  // green is summed at full precision, truncated once
  assign green_sum = up_data.prod_g_cb + up_data.prod_g_cr;

  always_comb begin
    stage_next.side   = up_data.side;
    stage_next.term_r = yck_pkg::drop_frac(up_data.prod_r);
    stage_next.term_g = yck_pkg::drop_frac(green_sum);
    stage_next.term_b = yck_pkg::drop_frac(up_data.prod_b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule

### rtl/yck_mix.sv
// Stage 4: luma add, saturation and background select into the output register.
`timescale 1ns / 1ps

module yck_mix (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  yck_pkg::term_t     up_data,
  output logic               dn_valid,
  input  logic               dn_ready,
  output yck_pkg::out_item_t dn_data
);

  localparam int unsigned PAD_W = yck_pkg::SUM_W - yck_pkg::PIX_W;

  yck_pkg::out_item_t stage_next;
  logic signed [yck_pkg::SUM_W-1:0] y1;
  logic signed [yck_pkg::SUM_W-1:0] y2;
  logic signed [yck_pkg::SUM_W-1:0] tr;
  logic signed [yck_pkg::SUM_W-1:0] tg;
  logic signed [yck_pkg::SUM_W-1:0] tb;

  assign up_ready = !dn_valid || dn_ready;

  assign y1 = {{PAD_W{1'b0}}, up_data.side.luma_first};
  assign y2 = {{PAD_W{1'b0}}, up_data.side.luma_second};
  assign tr = yck_pkg::SUM_W'(up_data.term_r);
  assign tg = yck_pkg::SUM_W'(up_data.term_g);
  assign tb = yck_pkg::SUM_W'(up_data.term_b);

  always_comb begin
    if (up_data.side.keyed) begin
      stage_next.out_blue_first   = up_data.side.bg_blue_first;
      stage_next.out_green_first  = up_data.side.bg_green_first;
      stage_next.out_red_first    = up_data.side.bg_red_first;
      stage_next.out_blue_second  = up_data.side.bg_blue_second;
      stage_next.out_green_second = up_data.side.bg_green_second;
      stage_next.out_red_second   = up_data.side.bg_red_second;
    end else begin
      stage_next.out_blue_first   = yck_pkg::clamp_channel(y1 + tb);
      stage_next.out_green_first  = yck_pkg::clamp_channel(y1 - tg);
      stage_next.out_red_first    = yck_pkg::clamp_channel(y1 + tr);
      stage_next.out_blue_second  = yck_pkg::clamp_channel(y2 + tb);
      stage_next.out_green_second = yck_pkg::clamp_channel(y2 - tg);
      stage_next.out_red_second   = yck_pkg::clamp_channel(y2 + tr);
    end
    stage_next.is_background = up_data.side.keyed;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dn_valid <= 1'b0;
    end else if (up_ready) begin
      dn_valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      dn_data <= stage_next;
    end
  end

endmodule
